>>> src/mp2_pkg.sv
// ---------------------------------------------------------------------------
// mp2_pkg: shared definitions for the 2x2 max pooling block
// Configuration register indexes, reset values, limits and the control
// bundle that passes from the sequencer to the datapath.
// ---------------------------------------------------------------------------
package mp2_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET   = 7'd24;
    localparam logic [CFG_W-1:0] HEIGHT_RESET  = 7'd24;
    localparam logic [CFG_W-1:0] CHANNEL_RESET = 7'd20;

    localparam logic [CFG_W-1:0] HEIGHT_MIN    = 7'd2;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT  = 7'd64;
    localparam logic [CFG_W-1:0] CHANNEL_MIN   = 7'd1;
    localparam logic [CFG_W-1:0] CHANNEL_LIMIT = 7'd64;

    // Per-sample actions decided at the input.
    typedef struct packed {
        logic wr;    // store the pair maximum of an even row
        logic rd;    // read the stored pair maximum, a pooled value follows
        logic done;  // the pooled value closes the whole map
    } step_ctl_t;

endpackage

>>> src/mp2_ram.sv
// ---------------------------------------------------------------------------
// mp2_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. The read data holds until
// the next read.
// ---------------------------------------------------------------------------
module mp2_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/mp2_ctrl.sv
// ---------------------------------------------------------------------------
// mp2_ctrl: position sequencer and pair maximum
// Holds the configuration registers, the column/row/channel counters and
// the running maximum of the current column pair, and decides per sample
// whether the line store is written or read.
// ---------------------------------------------------------------------------
module mp2_ctrl #(
    parameter int MAX_WIDTH   = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int ADDR_W     = $clog2(MAX_WIDTH / 2)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mp2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mp2_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               accept,
    input  logic signed [SAMPLE_BITS-1:0]      pixel_value,
    output mp2_pkg::step_ctl_t                 step,
    output logic [ADDR_W-1:0]                  addr,
    output logic signed [SAMPLE_BITS-1:0]      pair_value
);

    localparam int CIDX_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);

    logic [mp2_pkg::CFG_W-1:0] width_reg;
    logic [mp2_pkg::CFG_W-1:0] height_reg;
    logic [mp2_pkg::CFG_W-1:0] channel_reg;

    logic [CIDX_W-1:0]             col_reg, col_next;
    logic [mp2_pkg::IDX_W-1:0]     row_reg, row_next;
    logic [mp2_pkg::IDX_W-1:0]     ch_reg, ch_next;
    logic signed [SAMPLE_BITS-1:0] pair_reg, pair_next;

    logic [31:0]               width_raw, width_sat;
    logic [COL_W-1:0]          width_lim, width_even;
    logic [mp2_pkg::CFG_W-1:0] height_lim, height_even, channel_lim;
    logic [COL_W-1:0]          col_ext, col_inc;
    logic [mp2_pkg::CFG_W-1:0] row_inc, ch_inc, row_ext;
    logic                      in_window;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= mp2_pkg::WIDTH_RESET;
            height_reg  <= mp2_pkg::HEIGHT_RESET;
            channel_reg <= mp2_pkg::CHANNEL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mp2_pkg::CFG_MAP_WIDTH:     width_reg   <= cfg_data;
                mp2_pkg::CFG_MAP_HEIGHT:    height_reg  <= cfg_data;
                mp2_pkg::CFG_CHANNEL_COUNT: channel_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Saturate the sizes into their meaningful ranges.
    always_comb
    begin
        width_raw = 32'(width_reg);
        if (width_raw < 32'd2)
        begin
            width_sat = 32'd2;
        end
        else if (width_raw > 32'(MAX_WIDTH))
        begin
            width_sat = 32'(MAX_WIDTH);
        end
        else
        begin
            width_sat = width_raw;
        end
        width_lim  = width_sat[COL_W-1:0];
        width_even = {width_lim[COL_W-1:1], 1'b0};

        if (height_reg < mp2_pkg::HEIGHT_MIN)
        begin
            height_lim = mp2_pkg::HEIGHT_MIN;
        end
        else if (height_reg > mp2_pkg::HEIGHT_LIMIT)
        begin
            height_lim = mp2_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            height_lim = height_reg;
        end
        height_even = {height_lim[mp2_pkg::CFG_W-1:1], 1'b0};

        if (channel_reg < mp2_pkg::CHANNEL_MIN)
        begin
            channel_lim = mp2_pkg::CHANNEL_MIN;
        end
        else if (channel_reg > mp2_pkg::CHANNEL_LIMIT)
        begin
            channel_lim = mp2_pkg::CHANNEL_LIMIT;
        end
        else
        begin
            channel_lim = channel_reg;
        end
    end

    // Per-sample decisions, pair maximum and position advance.
    always_comb
    begin
        col_ext = COL_W'(col_reg);
        col_inc = col_ext + COL_W'(1);
        row_ext = {1'b0, row_reg};
        row_inc = row_ext + 7'd1;
        ch_inc  = {1'b0, ch_reg} + 7'd1;

        if (col_reg[0])
        begin
            pair_next = (pixel_value > pair_reg) ? pixel_value : pair_reg;
        end
        else
        begin
            pair_next = pixel_value;
        end

        // An odd column inside the even-rounded width and inside the height.
        in_window = col_reg[0] && (col_ext < width_even) && (row_ext < height_lim);

        step.wr   = in_window && !row_reg[0];
        step.rd   = in_window && row_reg[0] && (row_ext < height_even);
        step.done = (col_inc >= width_even) && (row_inc >= height_even)
                    && (ch_inc >= channel_lim);

        col_next = col_reg;
        row_next = row_reg;
        ch_next  = ch_reg;
        if (col_inc >= width_lim)
        begin
            col_next = '0;
            if (row_inc >= height_lim)
            begin
                row_next = '0;
                if (ch_inc >= channel_lim)
                begin
                    ch_next = '0;
                end
                else
                begin
                    ch_next = ch_inc[mp2_pkg::IDX_W-1:0];
                end
            end
            else
            begin
                row_next = row_inc[mp2_pkg::IDX_W-1:0];
            end
        end
        else
        begin
            col_next = col_inc[CIDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ch_reg   <= '0;
            pair_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ch_reg   <= ch_next;
            pair_reg <= pair_next;
        end
    end

    // Only odd columns below the even-rounded width reach the store, so the
    // slot always fits the address.
    assign addr       = col_reg[ADDR_W:1];
    assign pair_value = pair_next;

endmodule

>>> src/max_pool_2x2_stride2.sv
// ---------------------------------------------------------------------------
// max_pool_2x2_stride2: streaming 2x2 max pooling, stride 2
// Samples arrive in channel-major raster order. Even rows leave the maximum
// of each column pair in a line store; odd rows combine it with their own
// pair maximum and emit one pooled value per window.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   input    | in_valid, in_ready, pixel_value       | in
//   output   | out_valid, out_ready, pooled_value,   | out
//            | map_done                              |
//   config   | cfg_write, cfg_index, cfg_data        | in
//
// One sample is taken per cycle; a pooled value follows the sample that
// completes its window through the line store read in the read stage and
// then the output register. The line store has one write and one read port,
// which sets the rate of one sample per cycle. Reset clears the counters and
// the pair maximum; the line store needs no clearing. A stalled output holds
// its transaction, and input is taken as long as the pending stage can drain.
// ---------------------------------------------------------------------------
module max_pool_2x2_stride2 #(
    parameter int MAX_WIDTH   = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [mp2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mp2_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] pixel_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] pooled_value,
    output logic                          map_done
);

    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    mp2_pkg::step_ctl_t            step;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] pair_value;
    logic [SAMPLE_BITS-1:0]        store_rdata;
    logic signed [SAMPLE_BITS-1:0] stored_max;
    logic                          accept;
    logic                          s1_move;

    logic                          s1_valid_reg, s1_valid_next;
    logic signed [SAMPLE_BITS-1:0] s1_pair_reg;
    logic                          s1_done_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] pooled_reg;
    logic                          done_reg;

    mp2_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel_value (pixel_value),
        .step        (step),
        .addr        (addr),
        .pair_value  (pair_value)
    );

    mp2_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && step.wr),
        .waddr (addr),
        .wdata (pair_value),
        .re    (accept && step.rd),
        .raddr (addr),
        .rdata (store_rdata)
    );

    assign stored_max = $signed(store_rdata);

    // The read stage moves on whenever the output register is free or drains.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = step.rd;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step.rd)
        begin
            s1_pair_reg <= pair_value;
            s1_done_reg <= step.done;
        end
        if (s1_move)
        begin
            pooled_reg <= (s1_pair_reg > stored_max) ? s1_pair_reg : stored_max;
            done_reg   <= s1_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pooled_value = pooled_reg;
    assign map_done     = done_reg;

`ifndef SYNTH
    // The store is never written and read by the same sample.
    a_no_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
        !(step.wr && step.rd))
        else $error("line store written and read by one sample");

    // A sample that reads the store always lands in the read stage.
    a_rd_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step.rd) |=> s1_valid_reg)
        else $error("store read lost before the read stage");

    // A blocked read stage keeps its pair maximum.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_pair_reg)))
        else $error("read stage changed while blocked");

    // The read stage moves only into the output register.
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("pooled value dropped on the way out");

    // No sample is taken while the read stage is full and blocked.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !accept)
        else $error("sample taken over a blocked read stage");
`endif

endmodule
